### hw/rtl/fcw_pkg.sv
// Package for the FAT cluster chain block walker.
// Command, result kind and table format codes, plus block size constants.
// No dependencies.
package fcw_pkg;

   localparam int unsigned BLOCK_BYTES = 512;
   localparam int unsigned BLOCK_SHIFT = 9;

   // input commands
   localparam logic [1:0] CMD_OPEN = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;
   localparam logic [1:0] CMD_WORD = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_TABLE  = 2'd1;
   localparam logic [1:0] KIND_EOF    = 2'd2;
   localparam logic [1:0] KIND_OPENED = 2'd3;

   // table formats; code 3 behaves as FAT32
   localparam logic [1:0] FAT_12 = 2'd0;
   localparam logic [1:0] FAT_16 = 2'd1;
   localparam logic [1:0] FAT_32 = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_FAT_KIND   = 2'd0;
   localparam logic [1:0] REG_TABLE_BASE = 2'd1;
   localparam logic [1:0] REG_DATA_BASE  = 2'd2;
   localparam logic [1:0] REG_CLUSTER    = 2'd3;

   // end of chain markers
   localparam logic [11:0] EOC_FAT12 = 12'hff8;
   localparam logic [15:0] EOC_FAT16 = 16'hfff8;
   localparam logic [27:0] EOC_FAT32 = 28'hffffff8;

endpackage : fcw_pkg

### hw/rtl/fat_cluster_chain_block_walker_top.sv
// FAT cluster chain block walker: input register, single pass of logic, result register.
// Depends on fcw_pkg.
// An accepted item loads the input register; its result then loads the result register,
// raising rsp_valid unless rsp_stall holds the previous result. Throughput: one item
// per cycle while rsp_stall is low; the walk state is updated at the edge the result
// register loads, so the next item sees it at once. One 32x17 multiply sets the path.
// Reset (synchronous, active high): walk state and flags cleared, no item held,
// registers back to FAT16, zero bases, 512-byte clusters.
module fat_cluster_chain_block_walker_top
   import fcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_start_cluster,
   input  logic [31:0] req_file_bytes,
   input  logic [31:0] req_table_word,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [22:0] rsp_block_number,
   output logic [8:0]  rsp_byte_in_block,
   output logic [9:0]  rsp_byte_count,
   output logic        rsp_last_block,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration
   logic [1:0]  fat_kind_ff;
   logic [31:0] table_base_ff;
   logic [31:0] data_base_ff;
   logic [16:0] cluster_bytes_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_cmd_ff;
   logic [31:0] in_start_ff;
   logic [31:0] in_bytes_ff;
   logic [31:0] in_word_ff;

   // walk state
   logic [31:0] cur_cluster_ff, cur_cluster_in;
   logic [16:0] offset_ff, offset_in;
   logic [31:0] bytes_left_ff, bytes_left_in;
   logic        at_end_ff, at_end_in;
   logic        awaiting_ff, awaiting_in;

   // result register
   logic        out_valid_ff;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [22:0] out_block_ff, out_block_in;
   logic [8:0]  out_byte_ff, out_byte_in;
   logic [9:0]  out_count_ff, out_count_in;
   logic        out_last_ff, out_last_in;
   logic        res_valid;

   logic        fire;
   logic        take;

   // datapath
   logic [31:0] next_entry;
   logic        chain_end;
   logic        use_next;
   logic [31:0] clus_sel;
   logic [16:0] off_sel;
   logic [31:0] clus_rel;
   logic [31:0] clus_prod;
   logic [31:0] data_addr;
   logic [31:0] tri_cluster;
   logic [31:0] table_off;
   logic [31:0] table_addr;
   logic        short_tail;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign take      = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !fire);
   assign csr_ready = 1'b1;

   // table entry decode
   always_comb begin
      case (fat_kind_ff)
         FAT_12: begin
            if (cur_cluster_ff[0]) begin
               next_entry = {20'd0, in_word_ff[15:4]};
            end else begin
               next_entry = {20'd0, in_word_ff[11:0]};
            end
            chain_end = next_entry[11:0] >= EOC_FAT12;
         end
         FAT_16: begin
            next_entry = {16'd0, in_word_ff[15:0]};
            chain_end  = next_entry[15:0] >= EOC_FAT16;
         end
         default: begin
            next_entry = {4'd0, in_word_ff[27:0]};
            chain_end  = next_entry[27:0] >= EOC_FAT32;
         end
      endcase
   end

   // after a returned word the data request runs on the next cluster
   assign use_next  = (in_cmd_ff == CMD_WORD);
   assign clus_sel  = use_next ? next_entry : cur_cluster_ff;
   assign off_sel   = use_next ? (offset_ff - cluster_bytes_ff) : offset_ff;
   assign clus_rel  = clus_sel - 32'd2;
   assign clus_prod = clus_rel * {15'd0, cluster_bytes_ff};
   assign data_addr = data_base_ff + clus_prod + {15'd0, off_sel};
   assign short_tail = (bytes_left_ff[31:BLOCK_SHIFT] == '0);

   // cluster * 3 / 2 wraps in 32 bits before the halving
   assign tri_cluster = cur_cluster_ff + {cur_cluster_ff[30:0], 1'b0};
   always_comb begin
      case (fat_kind_ff)
         FAT_12:  table_off = {1'b0, tri_cluster[31:1]};
         FAT_16:  table_off = {cur_cluster_ff[30:0], 1'b0};
         default: table_off = {cur_cluster_ff[29:0], 2'b00};
      endcase
   end
   assign table_addr = table_base_ff + table_off;

   always_comb begin
      logic do_data;
      do_data        = 1'b0;
      cur_cluster_in = cur_cluster_ff;
      offset_in      = offset_ff;
      bytes_left_in  = bytes_left_ff;
      at_end_in      = at_end_ff;
      awaiting_in    = awaiting_ff;
      res_valid      = 1'b0;
      out_kind_in    = KIND_EOF;
      out_block_in   = '0;
      out_byte_in    = '0;
      out_count_in   = '0;
      out_last_in    = 1'b0;

      case (in_cmd_ff)
         CMD_OPEN: begin
            cur_cluster_in = in_start_ff;
            bytes_left_in  = in_bytes_ff;
            offset_in      = '0;
            at_end_in      = 1'b0;
            awaiting_in    = 1'b0;
            res_valid      = 1'b1;
            out_kind_in    = KIND_OPENED;
         end
         CMD_READ: begin
            res_valid = 1'b1;
            if (at_end_ff) begin
               out_kind_in = KIND_EOF;
            end else if (offset_ff >= cluster_bytes_ff) begin
               awaiting_in  = 1'b1;
               out_kind_in  = KIND_TABLE;
               out_block_in = table_addr[31:BLOCK_SHIFT];
               out_byte_in  = table_addr[BLOCK_SHIFT-1:0];
            end else begin
               do_data = 1'b1;
            end
         end
         CMD_WORD: begin
            // stray words are dropped without a result
            if (awaiting_ff && !at_end_ff) begin
               res_valid   = 1'b1;
               awaiting_in = 1'b0;
               if (chain_end) begin
                  at_end_in   = 1'b1;
                  out_kind_in = KIND_EOF;
               end else begin
                  cur_cluster_in = next_entry;
                  offset_in      = off_sel;
                  do_data        = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (do_data) begin
         awaiting_in  = 1'b0;
         out_kind_in  = KIND_DATA;
         out_block_in = data_addr[31:BLOCK_SHIFT];
         if (short_tail) begin
            at_end_in    = 1'b1;
            out_count_in = bytes_left_ff[9:0];
            out_last_in  = 1'b1;
         end else begin
            bytes_left_in = bytes_left_ff - 32'(BLOCK_BYTES);
            offset_in     = off_sel + 17'(BLOCK_BYTES);
            out_count_in  = 10'(BLOCK_BYTES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fat_kind_ff      <= FAT_16;
         table_base_ff    <= '0;
         data_base_ff     <= '0;
         cluster_bytes_ff <= 17'(BLOCK_BYTES);
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         cur_cluster_ff   <= '0;
         offset_ff        <= '0;
         bytes_left_ff    <= '0;
         at_end_ff        <= 1'b0;
         awaiting_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FAT_KIND:   fat_kind_ff      <= csr_wdata[1:0];
               REG_TABLE_BASE: table_base_ff    <= csr_wdata;
               REG_DATA_BASE:  data_base_ff     <= csr_wdata;
               REG_CLUSTER:    cluster_bytes_ff <= csr_wdata[16:0];
               default: begin
               end
            endcase
         end
         in_valid_ff <= in_valid_in;
         if (fire) begin
            out_valid_ff   <= res_valid;
            cur_cluster_ff <= cur_cluster_in;
            offset_ff      <= offset_in;
            bytes_left_ff  <= bytes_left_in;
            at_end_ff      <= at_end_in;
            awaiting_ff    <= awaiting_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_cmd_ff   <= req_cmd;
         in_start_ff <= req_start_cluster;
         in_bytes_ff <= req_file_bytes;
         in_word_ff  <= req_table_word;
      end
      if (fire) begin
         out_kind_ff  <= out_kind_in;
         out_block_ff <= out_block_in;
         out_byte_ff  <= out_byte_in;
         out_count_ff <= out_count_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_block_number  = out_block_ff;
   assign rsp_byte_in_block = out_byte_ff;
   assign rsp_byte_count    = out_count_ff;
   assign rsp_last_block    = out_last_ff;

   // the last data block of a file must leave the walker at end of file
   a_last_sets_end: assert property (@(posedge clock) disable iff (reset)
      fire && res_valid && out_kind_in == KIND_DATA && out_last_in |=> at_end_ff)
      else $error("last block issued without end of file");

   // a table request always leaves a word pending
   a_table_pends: assert property (@(posedge clock) disable iff (reset)
      fire && res_valid && out_kind_in == KIND_TABLE |=> awaiting_ff)
      else $error("table request without pending word");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count <= 10'(BLOCK_BYTES))
      else $error("byte count above block size");

   a_last_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_block |-> rsp_kind == KIND_DATA)
      else $error("last block flag on a non-data result");

endmodule : fat_cluster_chain_block_walker_top
